// File: rtl/mipdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mipdb_pkg;

    localparam int NUM_INPUTS  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = 2;
    localparam int LIVE_W      = 3;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CANCELLED   = 3'd1;
    localparam logic [2:0] ST_NOT_STARTED = 3'd2;
    localparam logic [2:0] ST_EMPTY       = 3'd3;
    localparam logic [2:0] ST_NOT_DUE     = 3'd4;
    localparam logic [2:0] ST_DUPLICATE   = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd6;
    localparam logic [2:0] ST_FULL        = 3'd7;

    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic signed [47:0] dts;
        logic [31:0]        seq;
        logic [15:0]        handle;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/multi_input_playout_delay_buffer_unit.sv
// channel  | handshake        | payload
// s_ (in)  | s_valid/s_ready  | s_kind s_input_index s_packet_dts s_packet_sequence s_packet_handle
// m_ (out) | m_valid/m_ready  | m_status m_out_handle m_out_dts m_out_sequence m_started
//          |                  | m_last_dts m_last_dts_valid m_playback_cursor
// cfg      | APB, pready = 1  | delay_us at 0x0, active_inputs at 0x4
//
// Each beat: the accept edge applies the item to the cell chains,
// then the S_FIN state runs the start check and loads the output register.
// One item in flight; the next is taken once the result is registered.
// A stalled m_ side holds the block in its output cycle.
// Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module multi_input_playout_delay_buffer_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [1:0]         s_input_index,
    input  wire logic signed [47:0] s_packet_dts,
    input  wire logic [31:0]        s_packet_sequence,
    input  wire logic [15:0]        s_packet_handle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [15:0]             m_out_handle,
    output logic signed [47:0]      m_out_dts,
    output logic [31:0]             m_out_sequence,
    output logic                    m_started,
    output logic signed [47:0]      m_last_dts,
    output logic                    m_last_dts_valid,
    output logic signed [47:0]      m_playback_cursor,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import mipdb_pkg::*;

    typedef enum logic {S_IDLE, S_FIN} state_t;

    state_t            state_reg;
    logic [31:0]       delay_reg;
    logic [2:0]        active_reg;
    logic              started_reg;
    logic              cancelled_reg;
    logic signed [47:0] origin_reg;
    logic [47:0]       elapsed_reg;
    logic              seen_reg     [NUM_INPUTS];
    logic signed [47:0] least_reg   [NUM_INPUTS];
    logic signed [47:0] great_reg   [NUM_INPUTS];

    logic [2:0]        status_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_ok_reg;
    logic              pushed_reg;
    entry_t            popped_reg;

    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    entry_t            m_ent_reg;
    logic              m_started_reg;
    logic signed [47:0] m_last_reg;
    logic              m_last_valid_reg;
    logic signed [47:0] m_cursor_reg;

    lane_ctrl_t        ctrl  [NUM_INPUTS];
    entry_t            heads [NUM_INPUTS];
    logic [CNT_W-1:0]  cnts  [NUM_INPUTS];
    logic [NUM_INPUTS-1:0] dups;

    entry_t            new_entry;
    logic [LIVE_W-1:0] live;
    logic              idx_ok;
    logic              accept;
    logic              out_free;
    logic [2:0]        status_next;
    logic              push_ok;
    logic              pop_ok;
    logic signed [49:0] offset;
    logic              not_due;
    logic              all_warm;
    logic signed [47:0] origin_min;
    logic              start_now;
    logic [48:0]       span;
    logic              cnt_any;

    assign new_entry = '{dts: s_packet_dts, seq: s_packet_sequence, handle: s_packet_handle};

    for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
        mipdb_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl[i]),
            .new_entry (new_entry),
            .head_o    (heads[i]),
            .count_o   (cnts[i]),
            .dup_o     (dups[i])
        );
    end

    always_comb begin
        if (active_reg == '0) begin
            live = LIVE_W'(1);
        end else if (active_reg > LIVE_W'(NUM_INPUTS)) begin
            live = LIVE_W'(NUM_INPUTS);
        end else begin
            live = active_reg;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_ok   = {1'b0, s_input_index} < live;

    assign offset  = 50'(heads[s_input_index].dts) - 50'(origin_reg);
    assign not_due = offset > $signed({2'b00, elapsed_reg});

    always_comb begin
        status_next = ST_OK;
        push_ok     = 1'b0;
        pop_ok      = 1'b0;
        case (s_kind)
            KIND_PUSH: begin
                if (!idx_ok) begin
                    status_next = ST_BAD_INDEX;
                end else if (cancelled_reg) begin
                    status_next = ST_CANCELLED;
                end else if (dups[s_input_index]) begin
                    status_next = ST_DUPLICATE;
                end else if (cnts[s_input_index] == CNT_W'(QUEUE_DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                end
            end
            KIND_TICK: begin
                status_next = cancelled_reg ? ST_CANCELLED : ST_OK;
            end
            KIND_POP: begin
                if (!idx_ok) begin
                    status_next = ST_BAD_INDEX;
                end else if (cancelled_reg) begin
                    status_next = ST_CANCELLED;
                end else if (!started_reg) begin
                    status_next = ST_NOT_STARTED;
                end else if (cnts[s_input_index] == '0) begin
                    status_next = ST_EMPTY;
                end else if (not_due) begin
                    status_next = ST_NOT_DUE;
                end else begin
                    pop_ok = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
            ctrl[i].push  = accept && push_ok && (s_input_index == IDX_W'(i));
            ctrl[i].pop   = accept && pop_ok && (s_input_index == IDX_W'(i));
            ctrl[i].clear = accept && (s_kind == KIND_CANCEL);
        end
    end

    always_comb begin
        all_warm   = 1'b1;
        origin_min = heads[0].dts;
        span       = '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            if (LIVE_W'(i) < live) begin
                span = 49'(great_reg[i]) - 49'(least_reg[i]);
                if (!seen_reg[i] || cnts[i] == '0 || span < {17'b0, delay_reg}) begin
                    all_warm = 1'b0;
                end
                if (heads[i].dts < origin_min) begin
                    origin_min = heads[i].dts;
                end
            end
        end
    end

    assign start_now = (state_reg == S_FIN) && out_free && pushed_reg &&
                       !started_reg && all_warm;

    always_comb begin
        cnt_any = 1'b0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
            cnt_any = cnt_any || (cnts[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            cancelled_reg <= 1'b0;
            origin_reg    <= '0;
            elapsed_reg   <= '0;
            m_valid_reg   <= 1'b0;
            pushed_reg    <= 1'b0;
            for (int i = 0; i < NUM_INPUTS; i++) begin
                seen_reg[i]  <= 1'b0;
                least_reg[i] <= '0;
                great_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg  <= S_FIN;
                        status_reg <= status_next;
                        idx_reg    <= s_input_index;
                        idx_ok_reg <= idx_ok;
                        pushed_reg <= push_ok;
                        popped_reg <= pop_ok ? heads[s_input_index] : '0;
                        if (s_kind == KIND_TICK) begin
                            elapsed_reg <= elapsed_reg + 48'd1;
                        end
                        if (s_kind == KIND_CANCEL) begin
                            cancelled_reg <= 1'b1;
                        end
                        if (push_ok) begin
                            seen_reg[s_input_index] <= 1'b1;
                            if (!seen_reg[s_input_index] ||
                                s_packet_dts < least_reg[s_input_index]) begin
                                least_reg[s_input_index] <= s_packet_dts;
                            end
                            if (!seen_reg[s_input_index] ||
                                s_packet_dts > great_reg[s_input_index]) begin
                                great_reg[s_input_index] <= s_packet_dts;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg        <= S_IDLE;
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= status_reg;
                        m_ent_reg        <= popped_reg;
                        m_started_reg    <= started_reg || start_now;
                        m_last_valid_reg <= idx_ok_reg && seen_reg[idx_reg];
                        m_last_reg       <= (idx_ok_reg && seen_reg[idx_reg]) ?
                                            great_reg[idx_reg] : '0;
                        if (start_now) begin
                            started_reg  <= 1'b1;
                            origin_reg   <= origin_min;
                            elapsed_reg  <= '0;
                            m_cursor_reg <= origin_min;
                        end else begin
                            m_cursor_reg <= started_reg ? (origin_reg + elapsed_reg) : '0;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_out_handle      = m_ent_reg.handle;
    assign m_out_dts         = m_ent_reg.dts;
    assign m_out_sequence    = m_ent_reg.seq;
    assign m_started         = m_started_reg;
    assign m_last_dts        = m_last_reg;
    assign m_last_dts_valid  = m_last_valid_reg;
    assign m_playback_cursor = m_cursor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= '0;
            active_reg <= 3'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_DELAY) begin
                delay_reg <= pwdata;
            end else begin
                active_reg <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE) ? {29'b0, active_reg} : delay_reg;
    assign pready = 1'b1;

    a_fin_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN))
        else $error("result cycle left while output blocked");

    a_started_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |=> started_reg)
        else $error("started flag dropped");

    a_cancel_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cancelled_reg |-> !cnt_any)
        else $error("store holds entries after cancel");

    a_start_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(started_reg) |-> $past(pushed_reg))
        else $error("playback started without a push");

endmodule
`default_nettype wire

// File: rtl/mipdb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mipdb_cell (
    input  wire logic                   aclk,
    input  wire mipdb_pkg::lane_ctrl_t  ctrl,
    input  wire logic                   valid,
    input  wire logic                   prev_ins,
    input  wire mipdb_pkg::entry_t      new_entry,
    input  wire mipdb_pkg::entry_t      left_entry,
    input  wire mipdb_pkg::entry_t      right_entry,
    output mipdb_pkg::entry_t           entry_o,
    output logic                        ins_o,
    output logic                        dup_o
);
    import mipdb_pkg::*;

    entry_t entry_reg;
    logic   gt;
    logic   eq;

    assign gt = (entry_reg.dts > new_entry.dts) ||
                ((entry_reg.dts == new_entry.dts) && (entry_reg.seq > new_entry.seq));
    assign eq = (entry_reg.dts == new_entry.dts) && (entry_reg.seq == new_entry.seq);
    assign ins_o   = !valid || gt;
    assign dup_o   = valid && eq;
    assign entry_o = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.push && ins_o) begin
            entry_reg <= prev_ins ? left_entry : new_entry;
        end else if (ctrl.pop) begin
            entry_reg <= right_entry;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mipdb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module mipdb_lane (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mipdb_pkg::lane_ctrl_t      ctrl,
    input  wire mipdb_pkg::entry_t          new_entry,
    output mipdb_pkg::entry_t               head_o,
    output logic [mipdb_pkg::CNT_W-1:0]     count_o,
    output logic                            dup_o
);
    import mipdb_pkg::*;

    logic [CNT_W-1:0]       count_reg;
    entry_t                 ents [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ins;
    logic [QUEUE_DEPTH-1:0] dup;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        mipdb_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .valid       (CNT_W'(k) < count_reg),
            .prev_ins    ((k > 0) ? ins[(k > 0) ? k - 1 : 0] : 1'b0),
            .new_entry   (new_entry),
            .left_entry  (ents[(k > 0) ? k - 1 : 0]),
            .right_entry (ents[(k < QUEUE_DEPTH - 1) ? k + 1 : k]),
            .entry_o     (ents[k]),
            .ins_o       (ins[k]),
            .dup_o       (dup[k])
        );
    end

    assign head_o  = ents[0];
    assign count_o = count_reg;
    assign dup_o   = |dup;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.clear) begin
            count_reg <= '0;
        end else if (ctrl.push) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire
